FILE: sv/sfb_pkg.sv
package sfb_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 1024;
	localparam int unsigned LEN_W           = 11;
	localparam int unsigned NSLOT           = 9;

	localparam logic [7:0]       FLAG_SECOND = 8'h5E;
	localparam logic [7:0]       ESC_SECOND  = 8'h5D;
	localparam logic [7:0]       FLAG_RST    = 8'h7E;
	localparam logic [7:0]       ESC_RST     = 8'h7D;
	localparam logic [LEN_W-1:0] MAXLEN_RST  = 11'd1024;

	typedef enum logic [1:0] {
		REG_FLAG   = 2'd0,
		REG_ESC    = 2'd1,
		REG_MAXLEN = 2'd2
	} reg_idx_t;

	// emission slots, in line order
	localparam int unsigned SLOT_OPEN  = 0;
	localparam int unsigned SLOT_ADDR  = 1;
	localparam int unsigned SLOT_CTRL  = 2;
	localparam int unsigned SLOT_HCS   = 3;
	localparam int unsigned SLOT_D0    = 4;
	localparam int unsigned SLOT_D1    = 5;
	localparam int unsigned SLOT_C0    = 6;
	localparam int unsigned SLOT_C1    = 7;
	localparam int unsigned SLOT_CLOSE = 8;

	typedef struct packed {
		logic       mode;
		logic [7:0] address;
		logic [7:0] control;
		logic [7:0] payload_byte;
		logic       first_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
		logic       overflow;
	} out_t;

	typedef struct packed {
		logic [7:0]       flag;
		logic [7:0]       esc;
		logic [LEN_W-1:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic [NSLOT-1:0] mask;
		logic [7:0]       addr;
		logic [7:0]       ctrl;
		logic [7:0]       d0;
		logic [7:0]       d1;
		logic [7:0]       c0;
		logic [7:0]       c1;
		logic             ovf;
	} cmd_t;

	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} stuffed_t;

	function automatic stuffed_t stuff(input logic [7:0] v, input logic [7:0] flag,
		input logic [7:0] esc);
		stuffed_t s;
		s.two = 1'b0;
		s.b0  = v;
		s.b1  = ESC_SECOND;
		if (v == flag) begin
			s.two = 1'b1;
			s.b0  = esc;
			s.b1  = FLAG_SECOND;
		end else if (v == esc) begin
			s.two = 1'b1;
			s.b0  = esc;
			s.b1  = ESC_SECOND;
		end
		return s;
	endfunction

endpackage

FILE: sv/sfb_front.sv
module sfb_front #(
	parameter int unsigned MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfb_pkg::cfg_t       cfg,
	input  logic                in_fire,
	input  sfb_pkg::in_t        item,
	output logic                push,
	output sfb_pkg::cmd_t       cmd
);

	localparam int unsigned LIM_MAX = (MAX_PAYLOAD < 2047) ? MAX_PAYLOAD : 2047;
	localparam int unsigned CW      = $clog2(LIM_MAX + 1);
	localparam int unsigned SW      = sfb_pkg::LEN_W + 1;

	logic [7:0]    check_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;

	logic [7:0]                 check_base, check_new;
	logic [CW-1:0]              count_base, count_new;
	logic                       ovf_base, ovf_new;
	logic [sfb_pkg::LEN_W-1:0]  limit;
	logic [SW-1:0]              sum;
	sfb_pkg::stuffed_t          pst, cst;

	always_comb begin
		limit = ({7'd0, cfg.max_len} > 18'(MAX_PAYLOAD)) ?
			sfb_pkg::LEN_W'(LIM_MAX) : cfg.max_len;
		check_base = item.first_byte ? 8'd0 : check_q;
		count_base = item.first_byte ? '0 : count_q;
		ovf_base   = item.first_byte ? 1'b0 : ovf_q;
		check_new  = check_base ^ item.payload_byte;
		pst        = sfb_pkg::stuff(item.payload_byte, cfg.flag, cfg.esc);
		cst        = sfb_pkg::stuff(check_new, cfg.flag, cfg.esc);
		sum        = SW'(count_base) + (pst.two ? SW'(2) : SW'(1));
		ovf_new    = ovf_base | (sum > SW'(limit));
		count_new  = ovf_new ? count_base : sum[CW-1:0];
	end

	always_comb begin
		cmd      = '0;
		cmd.addr = item.address;
		cmd.ctrl = item.control;
		cmd.d0   = pst.b0;
		cmd.d1   = pst.b1;
		cmd.c0   = cst.b0;
		cmd.c1   = cst.b1;
		if (!item.mode) begin
			cmd.mask[sfb_pkg::SLOT_OPEN]  = 1'b1;
			cmd.mask[sfb_pkg::SLOT_ADDR]  = 1'b1;
			cmd.mask[sfb_pkg::SLOT_CTRL]  = 1'b1;
			cmd.mask[sfb_pkg::SLOT_HCS]   = 1'b1;
			cmd.mask[sfb_pkg::SLOT_CLOSE] = 1'b1;
		end else begin
			cmd.ovf = ovf_new;
			cmd.mask[sfb_pkg::SLOT_OPEN]  = item.first_byte;
			cmd.mask[sfb_pkg::SLOT_ADDR]  = item.first_byte;
			cmd.mask[sfb_pkg::SLOT_CTRL]  = item.first_byte;
			cmd.mask[sfb_pkg::SLOT_HCS]   = item.first_byte;
			cmd.mask[sfb_pkg::SLOT_D0]    = !ovf_new;
			cmd.mask[sfb_pkg::SLOT_D1]    = !ovf_new && pst.two;
			cmd.mask[sfb_pkg::SLOT_C0]    = item.last_byte;
			cmd.mask[sfb_pkg::SLOT_C1]    = item.last_byte && cst.two;
			cmd.mask[sfb_pkg::SLOT_CLOSE] = item.last_byte;
		end
	end

	assign push = in_fire && (|cmd.mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_fire && item.mode) begin
			check_q <= check_new;
			count_q <= count_new;
			ovf_q   <= ovf_new;
		end
	end

	a_no_empty_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cmd.mask[sfb_pkg::SLOT_CLOSE] || cmd.mask[sfb_pkg::SLOT_D0] ||
			cmd.mask[sfb_pkg::SLOT_OPEN]))
		else $error("empty command pushed");

endmodule

FILE: sv/sfb_queue.sv
module sfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfb_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output sfb_pkg::cmd_t rdata
);

	sfb_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underrun");

endmodule

FILE: sv/sfb_back.sv
module sfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    flag,
	input  logic          q_empty,
	input  sfb_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output sfb_pkg::out_t out_data
);

	sfb_pkg::cmd_t                cur_q;
	logic [sfb_pkg::NSLOT-1:0]    mask_q;
	logic                         out_valid_q;
	sfb_pkg::out_t                out_q;

	logic                         adv, busy, emit, load;
	logic [sfb_pkg::NSLOT-1:0]    sel, mask_next;
	logic [7:0]                   byte_sel;

	assign adv       = !out_valid_q || out_ready;
	assign busy      = |mask_q;
	assign emit      = adv && busy;
	assign sel       = mask_q & (~mask_q + 1'b1);
	assign mask_next = mask_q & ~sel;
	assign load      = !q_empty && (!busy || (emit && mask_next == '0));
	assign q_pop     = load;

	always_comb begin
		case (1'b1)
			sel[sfb_pkg::SLOT_OPEN]:  byte_sel = flag;
			sel[sfb_pkg::SLOT_ADDR]:  byte_sel = cur_q.addr;
			sel[sfb_pkg::SLOT_CTRL]:  byte_sel = cur_q.ctrl;
			sel[sfb_pkg::SLOT_HCS]:   byte_sel = cur_q.addr ^ cur_q.ctrl;
			sel[sfb_pkg::SLOT_D0]:    byte_sel = cur_q.d0;
			sel[sfb_pkg::SLOT_D1]:    byte_sel = cur_q.d1;
			sel[sfb_pkg::SLOT_C0]:    byte_sel = cur_q.c0;
			sel[sfb_pkg::SLOT_C1]:    byte_sel = cur_q.c1;
			sel[sfb_pkg::SLOT_CLOSE]: byte_sel = flag;
			default:                  byte_sel = flag;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= q_data.mask;
			end else if (emit) begin
				mask_q <= mask_next;
			end
			if (adv) begin
				out_valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
		if (emit) begin
			out_q.out_byte  <= byte_sel;
			out_q.run_end   <= mask_next == '0;
			out_q.frame_end <= sel[sfb_pkg::SLOT_CLOSE];
			out_q.overflow  <= cur_q.ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_end) |-> out_q.run_end)
		else $error("closing flag not last beat of its run");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!busy || emit))
		else $error("command loaded over a busy one");

endmodule

FILE: sv/stuffed_frame_builder.sv
// An accepted item passes the queue, command register and output register before its first
//   line byte shows. One line byte per cycle while out_ready is high, set by the single
//   output byte register. A payload byte makes up to 2 line bytes (none after overflow),
//   up to 9 if it opens and closes a frame. Input is taken while the 2-entry queue has room.
// Reset (arst_n low): config back to flag 0x7E, escape 0x7D, limit 1024; frame state
//   and queue cleared; no output beat pending.
module stuffed_frame_builder #(
	parameter int unsigned MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sfb_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output sfb_pkg::out_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [sfb_pkg::LEN_W-1:0] cfg_data
);

	sfb_pkg::cfg_t cfg_q;
	sfb_pkg::cmd_t f_cmd, q_cmd;
	logic          in_fire, push, full, empty, pop;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag    <= sfb_pkg::FLAG_RST;
			cfg_q.esc     <= sfb_pkg::ESC_RST;
			cfg_q.max_len <= sfb_pkg::MAXLEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sfb_pkg::REG_FLAG:   cfg_q.flag    <= cfg_data[7:0];
				sfb_pkg::REG_ESC:    cfg_q.esc     <= cfg_data[7:0];
				sfb_pkg::REG_MAXLEN: cfg_q.max_len <= cfg_data;
				default:             ;
			endcase
		end
	end

	sfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_fire (in_fire),
		.item    (in_data),
		.push    (push),
		.cmd     (f_cmd)
	);

	sfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_cmd),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (q_cmd)
	);

	sfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.flag      (cfg_q.flag),
		.q_empty   (empty),
		.q_data    (q_cmd),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
